[rtl/core/i2c_eeprom_page_master_macros.svh]
// Assertion macros used by the EEPROM master sequencer.
// No dependencies.
`ifndef I2C_EEPROM_PAGE_MASTER_MACROS_SVH
`define I2C_EEPROM_PAGE_MASTER_MACROS_SVH
`define IEPM_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define IEPM_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/core/iepm_pkg.sv]
// Package for the EEPROM page master: phases, kinds, widths.
// No dependencies.
package iepm_pkg;
  localparam int AddrBits = 11;
  localparam int MaxLength = 2048;
  localparam int LenBits = 12;

  typedef enum logic [2:0] {
    PH_IDLE, PH_START, PH_SEND, PH_ACKW, PH_RECV, PH_MACK, PH_STOP, PH_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    BK_DEVW, BK_AHI, BK_ALO, BK_DATA, BK_DEVR
  } byte_kind_t;

  typedef enum logic [1:0] {
    SK_PAGE, SK_END, SK_NACK
  } stop_kind_t;

  typedef enum logic [1:0] {
    OP_TICK, OP_WRITE, OP_READ, OP_NONE
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_BUSERR = 2'd2;
  localparam logic [1:0] ST_NACK = 2'd3;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       need_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;
endpackage

[rtl/core/iepm_seq.sv]
// Tick sequencer: all bus state, one tick per accepted item.
// Depends on iepm_pkg.
module iepm_seq import iepm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           operation,
  input  logic [7:0]           device_code,
  input  logic [AddrBits-1:0]  mem_address,
  input  logic [LenBits-1:0]   length,
  input  logic [7:0]           write_byte,
  input  logic                 sda_in,
  input  logic [3:0]           page_size_log2,
  input  logic [15:0]          write_wait_ticks,
  output result_t              res
);
  phase_t phase, phase_next;
  byte_kind_t byte_kind, byte_kind_next;
  stop_kind_t stop_kind, stop_kind_next;
  logic [2:0] tick_step, tick_step_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next, dev_byte, dev_byte_next;
  logic [AddrBits-1:0] cur_address, cur_address_next;
  logic [LenBits-1:0] bytes_left, bytes_left_next;
  logic [8:0] page_left, page_left_next;
  logic [15:0] wait_count, wait_count_next;
  logic is_read, is_read_next, sda_level, sda_level_next, want_byte, want_byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; byte_kind <= BK_DEVW; stop_kind <= SK_PAGE;
      tick_step <= '0; bit_count <= '0; shift_byte <= '0; dev_byte <= '0;
      cur_address <= '0; bytes_left <= '0; page_left <= '0; wait_count <= '0;
      is_read <= 1'b0; sda_level <= 1'b1; want_byte <= 1'b0;
    end else if (step) begin
      phase <= phase_next; byte_kind <= byte_kind_next; stop_kind <= stop_kind_next;
      tick_step <= tick_step_next; bit_count <= bit_count_next;
      shift_byte <= shift_byte_next; dev_byte <= dev_byte_next;
      cur_address <= cur_address_next; bytes_left <= bytes_left_next;
      page_left <= page_left_next; wait_count <= wait_count_next;
      is_read <= is_read_next; sda_level <= sda_level_next; want_byte <= want_byte_next;
    end
  end

  always_comb begin
    logic [3:0] lg;
    logic [9:0] room;
    logic [9:0] offs;
    logic b;
    logic [LenBits-1:0] bl;
    logic [3:0] bc;
    phase_next = phase; byte_kind_next = byte_kind; stop_kind_next = stop_kind;
    tick_step_next = tick_step; bit_count_next = bit_count;
    shift_byte_next = want_byte ? write_byte : shift_byte;
    dev_byte_next = dev_byte; cur_address_next = cur_address;
    bytes_left_next = bytes_left; page_left_next = page_left;
    wait_count_next = wait_count; is_read_next = is_read;
    sda_level_next = sda_level; want_byte_next = 1'b0;
    res = '0; res.scl_out = 1'b1; res.sda_out = 1'b1;
    lg = (page_size_log2 > 4'd8) ? 4'd8 : page_size_log2;
    b = 1'b0; bl = '0; bc = '0;

    if (phase == PH_IDLE && (operation == OP_WRITE || operation == OP_READ)) begin
      dev_byte_next = device_code;
      cur_address_next = mem_address;
      bytes_left_next = (length > LenBits'(MaxLength)) ? LenBits'(MaxLength) : length;
      is_read_next = (operation == OP_READ);
      phase_next = PH_START;
      tick_step_next = '0;
      byte_kind_next = BK_DEVW;
    end
    // page room computed from current next address/length
    offs = 10'(cur_address_next) & ((10'd1 << lg) - 10'd1);
    room = (10'd1 << lg) - offs;
    if (phase == PH_IDLE && (operation == OP_WRITE || operation == OP_READ))
      page_left_next = (bytes_left_next < LenBits'(room)) ? 9'(bytes_left_next) : 9'(room);
    res.busy_res = (phase_next != PH_IDLE);

    case (phase_next)
      PH_START: begin
        if (tick_step == 3'd0) begin
          sda_level_next = 1'b1;
          if (!sda_in) begin
            res.done_res = 1'b1; res.status = ST_BUSY; phase_next = PH_IDLE;
          end else tick_step_next = 3'd1;
        end else if (tick_step == 3'd1) begin
          res.sda_out = 1'b0; sda_level_next = 1'b0;
          if (sda_in) begin
            res.done_res = 1'b1; res.status = ST_BUSERR; phase_next = PH_IDLE;
            tick_step_next = '0;
          end else tick_step_next = 3'd2;
        end else begin
          res.sda_out = 1'b0;
          case (byte_kind)
            BK_DEVW: shift_byte_next = (8'hA0 | dev_byte) & 8'hFE;
            BK_DEVR: shift_byte_next = 8'hA1 | dev_byte;
            default: ;
          endcase
          phase_next = PH_SEND; tick_step_next = '0; bit_count_next = '0;
        end
      end
      PH_SEND: begin
        b = shift_byte_next[3'd7 - bit_count[2:0]];
        if (tick_step == 3'd0) begin
          res.scl_out = 1'b0; res.sda_out = sda_level; tick_step_next = 3'd1;
        end else if (tick_step == 3'd1) begin
          res.scl_out = 1'b0; res.sda_out = b; sda_level_next = b; tick_step_next = 3'd2;
        end else begin
          res.sda_out = b; tick_step_next = '0;
          bc = bit_count + 4'd1;
          bit_count_next = bc;
          if (bc >= 4'd8) begin phase_next = PH_ACKW; bit_count_next = '0; end
        end
      end
      PH_ACKW: begin
        if (tick_step == 3'd0) begin
          res.scl_out = 1'b0; res.sda_out = sda_level; tick_step_next = 3'd1;
        end else if (tick_step == 3'd1) begin
          res.scl_out = 1'b0; sda_level_next = 1'b1; tick_step_next = 3'd2;
        end else begin
          tick_step_next = '0;
          if (sda_in) begin
            stop_kind_next = SK_NACK; phase_next = PH_STOP;
          end else begin
            case (byte_kind)
              BK_DEVW: begin
                byte_kind_next = BK_AHI; phase_next = PH_SEND; bit_count_next = '0;
                shift_byte_next = 8'(cur_address >> 8);
              end
              BK_AHI: begin
                byte_kind_next = BK_ALO; phase_next = PH_SEND; bit_count_next = '0;
                shift_byte_next = cur_address[7:0];
              end
              BK_ALO, BK_DATA: begin
                if (byte_kind == BK_ALO && is_read) begin
                  byte_kind_next = BK_DEVR; phase_next = PH_START;
                end else begin
                  if (byte_kind == BK_DATA) begin
                    cur_address_next = cur_address + 1'b1;
                    if (bytes_left != '0) bytes_left_next = bytes_left - 1'b1;
                    if (page_left != '0) page_left_next = page_left - 1'b1;
                  end
                  if (page_left_next != '0) begin
                    res.need_byte = 1'b1; want_byte_next = 1'b1;
                    byte_kind_next = BK_DATA; phase_next = PH_SEND; bit_count_next = '0;
                  end else begin
                    stop_kind_next = SK_PAGE; phase_next = PH_STOP;
                  end
                end
              end
              default: begin
                if (bytes_left == '0) begin
                  stop_kind_next = SK_END; phase_next = PH_STOP;
                end else begin
                  phase_next = PH_RECV; bit_count_next = '0; shift_byte_next = '0;
                end
              end
            endcase
          end
        end
      end
      PH_RECV: begin
        sda_level_next = 1'b1;
        if (tick_step == 3'd0) begin
          res.scl_out = 1'b0; tick_step_next = 3'd1;
        end else begin
          tick_step_next = '0;
          shift_byte_next = {shift_byte_next[6:0], sda_in};
          bc = bit_count + 4'd1;
          bit_count_next = bc;
          if (bc >= 4'd8) begin
            res.read_valid = 1'b1; res.read_byte = shift_byte_next;
            bit_count_next = '0;
            if (bytes_left != '0) bytes_left_next = bytes_left - 1'b1;
            phase_next = PH_MACK;
          end
        end
      end
      PH_MACK: begin
        res.sda_out = sda_level;
        if (tick_step == 3'd0) begin
          res.scl_out = 1'b0; tick_step_next = 3'd1;
        end else if (tick_step == 3'd1) begin
          res.scl_out = 1'b0; sda_level_next = (bytes_left == '0);
          res.sda_out = sda_level_next; tick_step_next = 3'd2;
        end else if (tick_step == 3'd2) begin
          tick_step_next = 3'd3;
        end else begin
          res.scl_out = 1'b0; tick_step_next = '0;
          if (bytes_left == '0) begin
            stop_kind_next = SK_END; phase_next = PH_STOP;
          end else begin
            phase_next = PH_RECV; shift_byte_next = '0; bit_count_next = '0;
          end
        end
      end
      PH_STOP: begin
        if (tick_step == 3'd0) begin
          res.scl_out = 1'b0; res.sda_out = sda_level; tick_step_next = 3'd1;
        end else if (tick_step == 3'd1) begin
          res.scl_out = 1'b0; res.sda_out = 1'b0; sda_level_next = 1'b0;
          tick_step_next = 3'd2;
        end else if (tick_step == 3'd2) begin
          res.sda_out = 1'b0; tick_step_next = 3'd3;
        end else begin
          sda_level_next = 1'b1; tick_step_next = '0;
          if (stop_kind == SK_NACK) begin
            res.done_res = 1'b1; res.status = ST_NACK; phase_next = PH_IDLE;
          end else if (stop_kind == SK_END) begin
            res.done_res = 1'b1; phase_next = PH_IDLE;
          end else begin
            wait_count_next = write_wait_ticks;
            phase_next = PH_WAIT;
          end
        end
      end
      PH_WAIT: ;
      default: sda_level_next = 1'b1;
    endcase

    // Write wait countdown; a zero wait falls straight through.
    if (phase == PH_WAIT || (phase_next == PH_WAIT && phase == PH_STOP)) begin
      if (phase == PH_WAIT && wait_count != '0) wait_count_next = wait_count - 1'b1;
      if (wait_count_next == '0) begin
        bl = bytes_left_next;
        if (bl != '0) begin
          offs = 10'(cur_address_next) & ((10'd1 << lg) - 10'd1);
          room = (10'd1 << lg) - offs;
          page_left_next = (bl < LenBits'(room)) ? 9'(bl) : 9'(room);
          byte_kind_next = BK_DEVW; phase_next = PH_START; tick_step_next = '0;
        end else begin
          res.done_res = 1'b1; phase_next = PH_IDLE; tick_step_next = '0;
        end
      end
    end
  end

  `include "i2c_eeprom_page_master_macros.svh"
  `IEPM_ASSERT_IMP(a_done_busy, clk, rst, step && res.done_res, res.busy_res)
  `IEPM_ASSERT_IMP(a_rv_recv, clk, rst, step && res.read_valid, phase == PH_RECV)
  `IEPM_ASSERT_NXT(a_done_idle, clk, rst, step && res.done_res, phase == PH_IDLE)
endmodule

[rtl/core/i2c_eeprom_page_master.sv]
// Top level of the EEPROM page master: stream ports, config, output register.
// Depends on iepm_pkg and iepm_seq.
// Each input item is one bus tick and yields one result item in the next cycle;
// an item is taken every cycle while the output register is free or being
// drained, so the sustained rate is one item per clock. The sequencer state,
// the config registers and the output register are the only storage.
module i2c_eeprom_page_master import iepm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], device_code[9:2], mem_address[20:10], length[32:21],
  // write_byte[40:33], sda_in[41], zero fill to 48
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_out[0], sda_out[1], need_byte[2], read_valid[3], read_byte[11:4],
  // busy_res[12], done_res[13], status[15:14]
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [3:0] page_size_log2;
  logic [15:0] write_wait_ticks;
  logic step;
  result_t res, out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size_log2 <= 4'd5; write_wait_ticks <= 16'd10;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) page_size_log2 <= cfg_data[3:0];
      else write_wait_ticks <= cfg_data;
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign step = s_tvalid && s_tready;

  iepm_seq u_seq (
    .clk(clk), .rst(rst), .step(step),
    .operation(s_tdata[1:0]), .device_code(s_tdata[9:2]),
    .mem_address(s_tdata[20:10]), .length(s_tdata[32:21]),
    .write_byte(s_tdata[40:33]), .sda_in(s_tdata[41]),
    .page_size_log2(page_size_log2), .write_wait_ticks(write_wait_ticks),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (s_tready) m_tvalid <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (step) out_reg <= res;
  end
  assign m_tdata = {out_reg.status, out_reg.done_res, out_reg.busy_res, out_reg.read_byte,
                    out_reg.read_valid, out_reg.need_byte, out_reg.sda_out, out_reg.scl_out};
endmodule
